// ===== rtl/dbba_pkg.sv =====
`default_nettype none
package dbba_pkg;

  // disk geometry and request limits
  localparam int DISK_BLOCKS     = 128;
  localparam int MAX_FILE_BLOCKS = 32;

  // fixed field widths of the request and result
  localparam int OP_W      = 2;
  localparam int START_W   = 7;
  localparam int SIZE_W    = 6;
  localparam int OUT_BLK_W = 7;
  localparam int STATUS_W  = 2;

  // derived widths
  localparam int BLK_W   = $clog2(DISK_BLOCKS);
  localparam int END_W   = ((BLK_W > START_W) ? BLK_W : START_W) + 1;
  localparam int CNT_W   = $clog2(MAX_FILE_BLOCKS + 2);

  // bitmap split into a row of cells
  localparam int CELL_BITS = 8;
  localparam int LOW_W     = $clog2(CELL_BITS);
  localparam int NUM_CELLS = (DISK_BLOCKS + CELL_BITS - 1) / CELL_BITS;
  localparam int CIDX_W    = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_CONTIG  = 2'd0,
    OP_LINKED  = 2'd1,
    OP_INDEXED = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RUN   = 2'd1,
    ST_FEW   = 2'd2,
    ST_NOIDX = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_FIND,
    CMD_CHECK,
    CMD_SET
  } cell_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIND,
    S_CHECK,
    S_MARK,
    S_FINAL
  } state_e;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    cell_cmd_e          cmd;
    logic [END_W-1:0]   run_lo;
    logic [END_W-1:0]   run_hi;
    logic [END_W-1:0]   set_addr;
  } cell_ctl_t;

  // what a cell reports back, zero unless it holds the token
  typedef struct packed {
    logic             hit;
    logic             conflict;
    logic [BLK_W-1:0] blk;
  } cell_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/dbba_cell.sv =====
`default_nettype none
module dbba_cell (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [dbba_pkg::CIDX_W-1:0] cell_idx_i,
  input  dbba_pkg::cell_ctl_t         ctl_i,
  input  logic                        tok_i,
  output logic                        tok_o,
  output dbba_pkg::cell_rsp_t         rsp_o
);
  import dbba_pkg::*;

  logic [CELL_BITS-1:0] map_q, map_d;
  logic [CELL_BITS-1:0] exists, avail, pick, in_run, at_addr;
  logic [END_W-1:0]     gaddr [CELL_BITS];
  logic [END_W-1:0]     base;
  logic [LOW_W-1:0]     pick_idx;
  logic                 tok_q, keep;

  // global block number of every bit in this cell
  always_comb begin
    base = END_W'(cell_idx_i) * END_W'(CELL_BITS);
    for (int j = 0; j < CELL_BITS; j++) begin
      gaddr[j]   = base + END_W'(j);
      exists[j]  = gaddr[j] < END_W'(DISK_BLOCKS);
      in_run[j]  = (gaddr[j] >= ctl_i.run_lo) && (gaddr[j] < ctl_i.run_hi);
      at_addr[j] = gaddr[j] == ctl_i.set_addr;
    end
  end

  // lowest free block in this cell
  always_comb begin
    avail    = exists & ~map_q;
    pick     = avail & (~avail + CELL_BITS'(1));
    pick_idx = '0;
    for (int j = 0; j < CELL_BITS; j++) begin
      if (pick[j]) begin
        pick_idx = LOW_W'(j);
      end
    end
  end

  // command decode, token hand-off
  always_comb begin
    map_d = map_q;
    keep  = 1'b0;
    tok_o = 1'b0;
    rsp_o = '0;
    case (ctl_i.cmd)
      CMD_FIND: begin
        if (tok_q) begin
          if (|avail) begin
            map_d     = map_q | pick;
            rsp_o.hit = 1'b1;
            rsp_o.blk = BLK_W'(base + END_W'(pick_idx));
            keep      = |(avail & ~pick);
            tok_o     = ~keep;
          end else begin
            tok_o = 1'b1;
          end
        end
      end
      CMD_CHECK: begin
        if (tok_q) begin
          rsp_o.conflict = |(in_run & map_q);
          tok_o          = 1'b1;
        end
      end
      CMD_SET: begin
        map_d = map_q | (at_addr & exists);
      end
      default: begin
      end
    endcase
  end

  // bitmap slice and token
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q <= '0;
      tok_q <= 1'b0;
    end else begin
      map_q <= map_d;
      tok_q <= tok_i | keep;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dbba_ctrl.sv =====
`default_nettype none
module dbba_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [dbba_pkg::OP_W-1:0]     op_i,
  input  logic [dbba_pkg::START_W-1:0]  start_block_i,
  input  logic [dbba_pkg::SIZE_W-1:0]   file_size_i,
  output logic                          valid_o,
  output logic [dbba_pkg::OUT_BLK_W-1:0] block_o,
  output logic                          granted_o,
  output logic                          is_index_o,
  output logic [dbba_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o,
  output dbba_pkg::cell_ctl_t           ctl_o,
  output logic                          launch_o,
  input  dbba_pkg::cell_rsp_t           rsp_i,
  input  logic                          end_i
);
  import dbba_pkg::*;

  state_e               state_q, state_d;
  logic [CNT_W-1:0]     remaining_q, remaining_d;
  logic                 idx_pend_q, idx_pend_d;
  logic                 bad_q, bad_d;
  logic [END_W-1:0]     addr_q, addr_d;
  logic [END_W-1:0]     run_hi_q, run_hi_d;
  status_e              status_q, status_d;

  logic                 valid_q, valid_d;
  logic [OUT_BLK_W-1:0] block_q, block_d;
  logic                 granted_q, granted_d;
  logic                 is_index_q, is_index_d;
  status_e              rstatus_q, rstatus_d;
  logic                 last_q, last_d;

  logic [CNT_W-1:0]     size_sat;
  logic [END_W-1:0]     run_end;
  logic                 range_bad;

  // request decode
  always_comb begin
    size_sat  = (file_size_i > SIZE_W'(MAX_FILE_BLOCKS)) ? CNT_W'(MAX_FILE_BLOCKS)
                                                        : CNT_W'(file_size_i);
    run_end   = END_W'(start_block_i) + END_W'(size_sat);
    range_bad = (END_W'(start_block_i) >= END_W'(DISK_BLOCKS)) ||
                (run_end > END_W'(DISK_BLOCKS));
  end

  // sequencer next state and outputs
  always_comb begin
    state_d      = state_q;
    remaining_d  = remaining_q;
    idx_pend_d   = idx_pend_q;
    bad_d        = bad_q;
    addr_d       = addr_q;
    run_hi_d     = run_hi_q;
    status_d     = status_q;
    valid_d      = 1'b0;
    block_d      = '0;
    granted_d    = 1'b0;
    is_index_d   = 1'b0;
    rstatus_d    = ST_OK;
    last_d       = 1'b0;
    launch_o     = 1'b0;
    ctl_o.cmd      = CMD_NONE;
    ctl_o.run_lo   = addr_q;
    ctl_o.run_hi   = run_hi_q;
    ctl_o.set_addr = addr_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          addr_d      = END_W'(start_block_i);
          run_hi_d    = run_end;
          bad_d       = 1'b0;
          idx_pend_d  = 1'b0;
          remaining_d = size_sat;
          case (op_e'(op_i))
            OP_CONTIG: begin
              if (range_bad) begin
                status_d = ST_RUN;
                state_d  = S_FINAL;
              end else if (size_sat == '0) begin
                status_d = ST_OK;
                state_d  = S_FINAL;
              end else begin
                launch_o = 1'b1;
                state_d  = S_CHECK;
              end
            end
            OP_LINKED: begin
              if (size_sat == '0) begin
                status_d = ST_OK;
                state_d  = S_FINAL;
              end else begin
                launch_o = 1'b1;
                state_d  = S_FIND;
              end
            end
            OP_INDEXED: begin
              remaining_d = size_sat + CNT_W'(1);
              idx_pend_d  = 1'b1;
              launch_o    = 1'b1;
              state_d     = S_FIND;
            end
            default: begin
              status_d = ST_RUN;
              state_d  = S_FINAL;
            end
          endcase
        end
      end

      // token walks the cells, one grant per cycle except while it crosses a full cell
      S_FIND: begin
        ctl_o.cmd = CMD_FIND;
        if (rsp_i.hit) begin
          valid_d     = 1'b1;
          block_d     = OUT_BLK_W'(rsp_i.blk);
          granted_d   = 1'b1;
          is_index_d  = idx_pend_q;
          last_d      = remaining_q == CNT_W'(1);
          remaining_d = remaining_q - CNT_W'(1);
          idx_pend_d  = 1'b0;
        end
        if (rsp_i.hit && (remaining_q == CNT_W'(1))) begin
          state_d = S_IDLE;
        end else if (end_i) begin
          status_d = (idx_pend_q && !rsp_i.hit) ? ST_NOIDX : ST_FEW;
          state_d  = S_FINAL;
        end
      end

      // token walks the cells looking for a used block in the run
      S_CHECK: begin
        ctl_o.cmd = CMD_CHECK;
        bad_d     = bad_q | rsp_i.conflict;
        if (end_i) begin
          if (bad_d) begin
            status_d = ST_RUN;
            state_d  = S_FINAL;
          end else begin
            state_d = S_MARK;
          end
        end
      end

      // mark the run one block per cycle
      S_MARK: begin
        ctl_o.cmd   = CMD_SET;
        valid_d     = 1'b1;
        block_d     = OUT_BLK_W'(addr_q);
        granted_d   = 1'b1;
        last_d      = remaining_q == CNT_W'(1);
        addr_d      = addr_q + END_W'(1);
        remaining_d = remaining_q - CNT_W'(1);
        if (remaining_q == CNT_W'(1)) begin
          state_d = S_IDLE;
        end
      end

      // closing result without a block
      S_FINAL: begin
        valid_d   = 1'b1;
        rstatus_d = status_q;
        last_d    = 1'b1;
        state_d   = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    remaining_q <= remaining_d;
    idx_pend_q  <= idx_pend_d;
    bad_q       <= bad_d;
    addr_q      <= addr_d;
    run_hi_q    <= run_hi_d;
    status_q    <= status_d;
    block_q     <= block_d;
    granted_q   <= granted_d;
    is_index_q  <= is_index_d;
    rstatus_q   <= rstatus_d;
    last_q      <= last_d;
  end

  assign busy       = state_q != S_IDLE;
  assign valid_o    = valid_q;
  assign block_o    = block_q;
  assign granted_o  = granted_q;
  assign is_index_o = is_index_q;
  assign status_o   = rstatus_q;
  assign last_o     = last_q;

endmodule
`default_nettype wire

// ===== rtl/disk_block_bitmap_allocator_core.sv =====
// Disk block allocator over a free/used bitmap of DISK_BLOCKS blocks.
// Request channel: op_i, start_block_i, file_size_i are taken at a rising
// edge with start high and busy low. busy stays high until the final result
// of the request is on the result ports.
// Result channel: one result per granted block, each shown for exactly one
// cycle with valid_o high; the receiver cannot stall it. The final result
// has last_o set and carries the status; on a failure, or on an empty
// contiguous or linked grant, it is an extra result with granted_o low.
// The bitmap lives in a row of 8-block cells; a token moves along the row.
// Linked/indexed: the token enters cell 0 and the first result is registered
// after it; then one result per cycle, except while the token crosses a full
// cell. Contiguous: the token first checks the run across every cell, then
// the run is marked and reported one block per cycle.
// A run out of range or an unknown method gives its single result via S_FINAL.
// A new request is taken in the cycle the final result shows.
// Reset marks every block free at once; no clearing pass.
`default_nettype none
module disk_block_bitmap_allocator_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [dbba_pkg::OP_W-1:0]     op_i,
  input  logic [dbba_pkg::START_W-1:0]  start_block_i,
  input  logic [dbba_pkg::SIZE_W-1:0]   file_size_i,
  output logic                          valid_o,
  output logic [dbba_pkg::OUT_BLK_W-1:0] block_o,
  output logic                          granted_o,
  output logic                          is_index_o,
  output logic [dbba_pkg::STATUS_W-1:0] status_o,
  output logic                          last_o
);
  import dbba_pkg::*;

  cell_ctl_t         ctl;
  cell_rsp_t         rsp_cell [NUM_CELLS];
  cell_rsp_t         rsp_all;
  logic [NUM_CELLS:0] tok;
  logic              launch;

  // sequencer
  dbba_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .start_block_i (start_block_i),
    .file_size_i   (file_size_i),
    .valid_o       (valid_o),
    .block_o       (block_o),
    .granted_o     (granted_o),
    .is_index_o    (is_index_o),
    .status_o      (status_o),
    .last_o        (last_o),
    .ctl_o         (ctl),
    .launch_o      (launch),
    .rsp_i         (rsp_all),
    .end_i         (tok[NUM_CELLS])
  );

  // row of bitmap cells, token enters at cell 0
  assign tok[0] = launch;

  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    dbba_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (CIDX_W'(c)),
      .ctl_i      (ctl),
      .tok_i      (tok[c]),
      .tok_o      (tok[c+1]),
      .rsp_o      (rsp_cell[c])
    );
  end

  // only the token holder reports, so the responses are simply ored
  always_comb begin
    rsp_all = '0;
    for (int c = 0; c < NUM_CELLS; c++) begin
      rsp_all = rsp_all | rsp_cell[c];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/dbba_chk.sv =====
`default_nettype none
module dbba_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          busy,
  input logic                          valid_o,
  input logic [dbba_pkg::OUT_BLK_W-1:0] block_o,
  input logic                          granted_o,
  input logic                          is_index_o,
  input logic [dbba_pkg::STATUS_W-1:0] status_o,
  input logic                          last_o
);
  import dbba_pkg::*;

  // a taken request always keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // a failing status only on a closing result without a block
  a_status_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && (status_o != ST_OK)) |-> (last_o && !granted_o))
    else $error("nonzero status on a non-final or granted result");

  // a result without a block is empty and closes the request
  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !granted_o) |-> (last_o && (block_o == '0) && !is_index_o))
    else $error("empty result malformed");

  // nothing follows the final result directly
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |=> !valid_o)
    else $error("result right after the final one");

  // the block is free again when the final result shows
  a_idle_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last_o) |-> !busy)
    else $error("still busy on the final result");

endmodule

bind disk_block_bitmap_allocator_core dbba_chk u_dbba_chk (.*);
`default_nettype wire
